// ----- rtl/rrub_pkg.sv -----
package rrub_pkg;

    localparam int BYTE_W    = 8;
    localparam int HALF_W    = 16;
    localparam int SHIFT_W   = 5;
    localparam int CIDX_W    = 3;
    localparam int CDATA_W   = 16;
    localparam int ADDR_W    = 34;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = 4;
    localparam int COORD_W   = HALF_W + 2;

    localparam logic [IDX_W-1:0] MSG_LAST_IDX  = 4'd3;
    localparam logic [IDX_W-1:0] RECT_LAST_IDX = 4'd11;
    localparam logic [IDX_W-1:0] PIX_LAST_IDX  = 4'd3;

    localparam logic [CIDX_W-1:0] CFG_RED_SHIFT   = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GREEN_SHIFT = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_BLUE_SHIFT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_X_OFFSET    = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_Y_OFFSET    = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_ROW_STRIDE  = 3'd5;

    typedef enum logic [1:0] {
        PH_MSG  = 2'd0,
        PH_RECT = 2'd1,
        PH_PIX  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [SHIFT_W-1:0] red_shift;
        logic [SHIFT_W-1:0] green_shift;
        logic [SHIFT_W-1:0] blue_shift;
        logic [HALF_W-1:0]  x_offset;
        logic [HALF_W-1:0]  y_offset;
        logic [HALF_W-1:0]  row_stride;
    } t_cfg;

    typedef struct packed {
        logic               emit;
        logic               msg_end;
        logic [HALF_W-1:0]  rect_x;
        logic [HALF_W-1:0]  column;
        logic [HALF_W-1:0]  rect_y;
        logic [HALF_W-1:0]  row;
        logic [BYTE_W-1:0]  red;
        logic [BYTE_W-1:0]  green;
        logic [BYTE_W-1:0]  blue;
    } t_pix;

endpackage

// ----- rtl/raw_rect_update_blitter.sv -----
// channel   direction  handshake                     payload
// in        input      i_in_valid / o_in_stall        i_byte_value
// out       output     o_out_valid / i_out_stall      o_fb_address, o_pixel_word, o_message_end
// cfg       input      i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// One byte per cycle unless i_out_stall holds the result register; the last byte of a
// pixel goes through the input register, then parse/address/shift into the result register.
// Synchronous active-low reset; the block is ready for a message right after it.
// o_in_stall rises only while a byte waits and the result register is held by i_out_stall.
// Config writes are always taken (o_cfg_ready is tied high).
module raw_rect_update_blitter import rrub_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [BYTE_W-1:0]  i_byte_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_fb_address,
    output logic [WORD_W-1:0]  o_pixel_word,
    output logic               o_message_end,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [CIDX_W-1:0]  i_cfg_index,
    input  logic [CDATA_W-1:0] i_cfg_data
);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_room, w_step, w_accept;
    t_cfg              w_cfg;
    t_pix              w_pix;

    assign o_cfg_ready = 1'b1;
    assign w_step      = r_in_vld && w_room;
    assign o_in_stall  = r_in_vld && !w_room;
    assign w_accept    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_accept) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_byte_value;
        end
    end

    rrub_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    rrub_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .o_pix   (w_pix)
    );

    rrub_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_pix         (w_pix),
        .i_cfg         (w_cfg),
        .i_stall       (i_out_stall),
        .o_room        (w_room),
        .o_valid       (o_out_valid),
        .o_fb_address  (o_fb_address),
        .o_pixel_word  (o_pixel_word),
        .o_message_end (o_message_end)
    );

    a_byte_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && o_out_valid && i_out_stall |=> r_in_vld)
        else $error("pending byte dropped while output held");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> r_in_vld)
        else $error("accepted byte not captured");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !r_in_vld)
        else $error("word pending after reset");

endmodule

// ----- rtl/rrub_cfg.sv -----
module rrub_cfg import rrub_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr,
    input  logic [CIDX_W-1:0]  i_index,
    input  logic [CDATA_W-1:0] i_data,
    output t_cfg               o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red_shift   <= SHIFT_W'(16);
            r_cfg.green_shift <= SHIFT_W'(8);
            r_cfg.blue_shift  <= '0;
            r_cfg.x_offset    <= '0;
            r_cfg.y_offset    <= '0;
            r_cfg.row_stride  <= '0;
        end else if (i_wr) begin
            case (i_index)
                CFG_RED_SHIFT:   r_cfg.red_shift   <= i_data[SHIFT_W-1:0];
                CFG_GREEN_SHIFT: r_cfg.green_shift <= i_data[SHIFT_W-1:0];
                CFG_BLUE_SHIFT:  r_cfg.blue_shift  <= i_data[SHIFT_W-1:0];
                CFG_X_OFFSET:    r_cfg.x_offset    <= i_data;
                CFG_Y_OFFSET:    r_cfg.y_offset    <= i_data;
                CFG_ROW_STRIDE:  r_cfg.row_stride  <= i_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/rrub_parse.sv -----
module rrub_parse import rrub_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    output t_pix              o_pix
);

    t_phase            r_phase, n_phase;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [HALF_W-1:0] r_rects, n_rects;
    logic [HALF_W-1:0] r_rx, n_rx, r_ry, n_ry, r_rw, n_rw, r_rh, n_rh;
    logic [HALF_W-1:0] r_col, n_col, r_row, n_row;
    logic [23:0]       r_color, n_color;
    logic              last_col, last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MSG;
            r_idx   <= '0;
            r_rects <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
            r_rw    <= '0;
            r_rh    <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_color <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_rects <= n_rects;
            r_rx    <= n_rx;
            r_ry    <= n_ry;
            r_rw    <= n_rw;
            r_rh    <= n_rh;
            r_col   <= n_col;
            r_row   <= n_row;
            r_color <= n_color;
        end
    end

    assign last_col = ({1'b0, r_col} + 17'd1) >= {1'b0, r_rw};
    assign last_row = ({1'b0, r_row} + 17'd1) >= {1'b0, r_rh};

    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_rects = r_rects;
        n_rx    = r_rx;
        n_ry    = r_ry;
        n_rw    = r_rw;
        n_rh    = r_rh;
        n_col   = r_col;
        n_row   = r_row;
        n_color = r_color;

        o_pix.emit    = 1'b0;
        o_pix.msg_end = last_col && last_row && (r_rects == '0);
        o_pix.rect_x  = r_rx;
        o_pix.column  = r_col;
        o_pix.rect_y  = r_ry;
        o_pix.row     = r_row;
        o_pix.red     = r_color[23:16];
        o_pix.green   = r_color[15:8];
        o_pix.blue    = r_color[7:0];

        case (r_phase)
            PH_RECT: begin
                case (r_idx)
                    4'd0: n_rx[15:8] = i_byte;
                    4'd1: n_rx[7:0]  = i_byte;
                    4'd2: n_ry[15:8] = i_byte;
                    4'd3: n_ry[7:0]  = i_byte;
                    4'd4: n_rw[15:8] = i_byte;
                    4'd5: n_rw[7:0]  = i_byte;
                    4'd6: n_rh[15:8] = i_byte;
                    4'd7: n_rh[7:0]  = i_byte;
                    default: ;
                endcase
                if (r_idx >= RECT_LAST_IDX) begin
                    n_rects = r_rects - 16'd1;
                    n_idx   = '0;
                    if (r_rw == '0 || r_rh == '0) begin
                        n_phase = (n_rects == '0) ? PH_MSG : PH_RECT;
                    end else begin
                        n_phase = PH_PIX;
                        n_col   = '0;
                        n_row   = '0;
                    end
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            PH_PIX: begin
                if (r_idx < PIX_LAST_IDX) begin
                    case (r_idx[1:0])
                        2'd0:    n_color[7:0]   = i_byte;
                        2'd1:    n_color[15:8]  = i_byte;
                        default: n_color[23:16] = i_byte;
                    endcase
                    n_idx = r_idx + 4'd1;
                end else begin
                    o_pix.emit = 1'b1;
                    n_idx      = '0;
                    if (last_col) begin
                        n_col = '0;
                        if (last_row) begin
                            n_row   = '0;
                            n_phase = (r_rects == '0) ? PH_MSG : PH_RECT;
                        end else begin
                            n_row = r_row + 16'd1;
                        end
                    end else begin
                        n_col = r_col + 16'd1;
                    end
                end
            end
            default: begin
                n_phase = PH_MSG;
                if (r_idx == 4'd2) n_rects[15:8] = i_byte;
                if (r_idx == 4'd3) n_rects[7:0]  = i_byte;
                if (r_idx >= MSG_LAST_IDX) begin
                    n_idx   = '0;
                    n_phase = (n_rects == '0) ? PH_MSG : PH_RECT;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
        endcase
    end

endmodule

// ----- rtl/rrub_out.sv -----
module rrub_out import rrub_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_pix              i_pix,
    input  t_cfg              i_cfg,
    input  logic              i_stall,
    output logic              o_room,
    output logic              o_valid,
    output logic [ADDR_W-1:0] o_fb_address,
    output logic [WORD_W-1:0] o_pixel_word,
    output logic              o_message_end
);

    logic              r_vld;
    logic [ADDR_W-1:0] r_addr;
    logic [WORD_W-1:0] r_word;
    logic              r_end;
    logic              load;
    logic [COORD_W-1:0] cx, cy;
    logic [ADDR_W-1:0]  prod, n_addr;
    logic [WORD_W-1:0]  n_word;

    assign o_room = !r_vld || !i_stall;
    assign load   = i_step && i_pix.emit;

    assign cx = COORD_W'(i_pix.rect_x) + COORD_W'(i_pix.column) + COORD_W'(i_cfg.x_offset);
    assign cy = COORD_W'(i_pix.rect_y) + COORD_W'(i_pix.row) + COORD_W'(i_cfg.y_offset);
    assign prod   = ADDR_W'(cy) * ADDR_W'(i_cfg.row_stride);
    assign n_addr = ADDR_W'({cx, 2'b00}) + prod;

    assign n_word = (WORD_W'(i_pix.red)   << i_cfg.red_shift)
                  | (WORD_W'(i_pix.green) << i_cfg.green_shift)
                  | (WORD_W'(i_pix.blue)  << i_cfg.blue_shift);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (!i_stall) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_addr <= n_addr;
            r_word <= n_word;
            r_end  <= i_pix.msg_end;
        end
    end

    assign o_valid       = r_vld;
    assign o_fb_address  = r_addr;
    assign o_pixel_word  = r_word;
    assign o_message_end = r_end;

endmodule
